[hw/rtl/elfr_pkg.sv]
// shared types and constants of the escaped length frame receiver
`default_nettype none

package elfr_pkg;

  localparam logic [7:0] FRAME_HEAD  = 8'h7E;
  localparam logic [7:0] ESCAPE_BYTE = 8'h7D;

  // configuration register indexes
  localparam logic [1:0] CFG_MAX_LEN  = 2'd0;
  localparam logic [1:0] CFG_CAPACITY = 2'd1;
  localparam logic [1:0] CFG_HDR_CODE = 2'd2;
  localparam logic [1:0] CFG_ESC_CODE = 2'd3;

  localparam logic [15:0] MAX_LEN_RESET  = 16'd1024;
  localparam logic [15:0] CAPACITY_RESET = 16'd1024;
  localparam logic [7:0]  HDR_CODE_RESET = 8'd94;
  localparam logic [7:0]  ESC_CODE_RESET = 8'd93;

  typedef enum logic [1:0] {
    EV_PAYLOAD   = 2'd0,
    EV_GOOD      = 2'd1,
    EV_CHECK_ERR = 2'd2,
    EV_OVERFLOW  = 2'd3
  } event_kind_t;

  typedef struct packed {
    logic [15:0] max_message_length;
    logic [15:0] frame_capacity;
    logic [7:0]  escaped_header_code;
    logic [7:0]  escaped_escape_code;
  } cfg_t;

  typedef struct packed {
    event_kind_t kind;
    logic [7:0]  payload_byte;
    logic [15:0] byte_position;
    logic [15:0] frame_length;
  } result_t;

endpackage

`default_nettype wire

[hw/rtl/elfr_cfg.sv]
// configuration register file
`default_nettype none

module elfr_cfg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_valid,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [15:0]   cfg_data,
  output elfr_pkg::cfg_t     cfg
);
  import elfr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_message_length  <= MAX_LEN_RESET;
      cfg.frame_capacity      <= CAPACITY_RESET;
      cfg.escaped_header_code <= HDR_CODE_RESET;
      cfg.escaped_escape_code <= ESC_CODE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MAX_LEN:  cfg.max_message_length  <= cfg_data;
        CFG_CAPACITY: cfg.frame_capacity      <= cfg_data;
        CFG_HDR_CODE: cfg.escaped_header_code <= cfg_data[7:0];
        CFG_ESC_CODE: cfg.escaped_escape_code <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/elfr_core.sv]
// deframing state machine with length, position and checksum registers
`default_nettype none

module elfr_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            fire,
  input  wire logic [7:0]      line_byte,
  input  wire elfr_pkg::cfg_t  cfg,
  output logic                 res_valid,
  output elfr_pkg::result_t    res
);
  import elfr_pkg::*;

  typedef enum logic [2:0] {
    PH_WAIT   = 3'd0,
    PH_LEN_HI = 3'd1,
    PH_LEN_LO = 3'd2,
    PH_DATA   = 3'd3,
    PH_CHECK  = 3'd4,
    PH_ESC    = 3'd5
  } phase_t;

  phase_t      phase, phase_next;
  phase_t      before_esc, before_esc_next;
  logic [15:0] announced_length, announced_length_next;
  logic [15:0] bytes_received, bytes_received_next;
  logic [7:0]  running_check, running_check_next;

  always_comb begin
    logic        take;
    phase_t      take_ph;
    logic [7:0]  u;
    logic [15:0] len;
    logic [15:0] cnt_inc;

    phase_next            = phase;
    before_esc_next       = before_esc;
    announced_length_next = announced_length;
    bytes_received_next   = bytes_received;
    running_check_next    = running_check;
    res_valid             = 1'b0;
    res                   = '0;
    take                  = 1'b0;
    take_ph               = phase;
    u                     = line_byte;
    len                   = {announced_length[15:8], u};
    cnt_inc               = bytes_received + 16'd1;

    if (phase == PH_ESC) begin
      take_ph = before_esc;
      if (line_byte == cfg.escaped_header_code) begin
        u    = FRAME_HEAD;
        take = 1'b1;
      end else if (line_byte == cfg.escaped_escape_code) begin
        u    = ESCAPE_BYTE;
        take = 1'b1;
      end else begin
        phase_next = PH_WAIT;
      end
    end else if (phase == PH_LEN_HI || phase == PH_LEN_LO ||
                 phase == PH_DATA || phase == PH_CHECK) begin
      if (line_byte == FRAME_HEAD) begin
        phase_next = PH_LEN_HI;
      end else if (line_byte == ESCAPE_BYTE) begin
        before_esc_next = phase;
        phase_next      = PH_ESC;
      end else begin
        take = 1'b1;
      end
    end else if (line_byte == FRAME_HEAD) begin
      phase_next = PH_LEN_HI;
    end else begin
      phase_next = PH_WAIT;
    end

    len = {announced_length[15:8], u};

    if (take) begin
      case (take_ph)
        PH_LEN_HI: begin
          announced_length_next = {u, 8'h00};
          running_check_next    = running_check ^ u;
          phase_next            = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          announced_length_next = len;
          running_check_next    = running_check ^ u;
          if (len > cfg.max_message_length) begin
            phase_next = PH_WAIT;
          end else if (len == '0) begin
            phase_next = PH_CHECK;
          end else begin
            phase_next = PH_DATA;
          end
        end
        PH_DATA: begin
          res_valid = 1'b1;
          if (bytes_received >= cfg.frame_capacity) begin
            res.kind   = EV_OVERFLOW;
            phase_next = PH_WAIT;
          end else begin
            res.kind            = EV_PAYLOAD;
            res.payload_byte    = u;
            res.byte_position   = bytes_received;
            bytes_received_next = cnt_inc;
            running_check_next  = running_check ^ u;
            phase_next = (cnt_inc >= announced_length) ? PH_CHECK : PH_DATA;
          end
        end
        PH_CHECK: begin
          res_valid  = 1'b1;
          phase_next = PH_WAIT;
          if (running_check == u) begin
            res.kind         = EV_GOOD;
            res.frame_length = announced_length;
          end else begin
            res.kind = EV_CHECK_ERR;
          end
        end
        default: phase_next = PH_WAIT;
      endcase
    end

    // leaving a frame or starting one wipes the per-frame registers
    if (phase_next == PH_WAIT || (phase_next == PH_LEN_HI && !take)) begin
      before_esc_next       = PH_WAIT;
      announced_length_next = '0;
      bytes_received_next   = '0;
      running_check_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_WAIT;
      before_esc       <= PH_WAIT;
      announced_length <= '0;
      bytes_received   <= '0;
      running_check    <= '0;
    end else if (fire) begin
      phase            <= phase_next;
      before_esc       <= before_esc_next;
      announced_length <= announced_length_next;
      bytes_received   <= bytes_received_next;
      running_check    <= running_check_next;
    end
  end

  a_esc_resume: assert property (@(posedge clk) disable iff (rst)
    phase == PH_ESC |-> (before_esc == PH_LEN_HI || before_esc == PH_LEN_LO ||
                         before_esc == PH_DATA || before_esc == PH_CHECK))
    else $error("escape resumes into a phase outside the frame");

  a_data_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> bytes_received < announced_length)
    else $error("data phase with all announced bytes received");

  a_wait_clear: assert property (@(posedge clk) disable iff (rst)
    phase == PH_WAIT |-> (bytes_received == '0 && running_check == '0 &&
                          announced_length == '0))
    else $error("frame registers not cleared while hunting");

endmodule

`default_nettype wire

[hw/rtl/elfr_out.sv]
// output register with skid stage
`default_nettype none

module elfr_out (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire elfr_pkg::result_t  push_res,
  output logic                    can_take,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output elfr_pkg::result_t       out_res
);
  import elfr_pkg::*;

  logic    skid_valid;
  result_t skid_res;

  // a free skid slot means one more word can land even if the consumer stalls
  assign can_take = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_ready) begin
      if (skid_valid) begin
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end else if (push) begin
        out_res <= push_res;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (!out_valid) begin
      if (push) begin
        out_res   <= push_res;
        out_valid <= 1'b1;
      end
    end else if (push) begin
      skid_res   <= push_res;
      skid_valid <= 1'b1;
    end
  end

  a_skid_behind: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a word while output is empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push)
    else $error("word pushed with both stages full");

endmodule

`default_nettype wire

[hw/rtl/escaped_length_frame_receiver_top.sv]
// Escaped length frame receiver: 0x7E header, 16-bit length, data, XOR checksum.
// Each result word is registered in the output stage, or in the skid slot on a stall.
// Throughput: one line byte per cycle, stalled by in_ready while the skid is full.
// A two-deep output stage keeps input flowing for one word while the consumer stalls.
// Reset clears the deframer to header hunting and loads the configuration defaults.
`default_nettype none

module escaped_length_frame_receiver_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  line_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       event_kind,
  output logic [7:0]       payload_byte,
  output logic [15:0]      byte_position,
  output logic [15:0]      frame_length,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import elfr_pkg::*;

  cfg_t    cfg;
  logic    fire;
  logic    res_valid;
  result_t res;
  result_t out_res;
  logic    can_take;

  assign cfg_ready = 1'b1;
  assign in_ready  = can_take;
  assign fire      = in_valid && can_take;

  elfr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  elfr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .line_byte (line_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  elfr_out u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (fire && res_valid),
    .push_res  (res),
    .can_take  (can_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign event_kind    = out_res.kind;
  assign payload_byte  = out_res.payload_byte;
  assign byte_position = out_res.byte_position;
  assign frame_length  = out_res.frame_length;

endmodule

`default_nettype wire

[test/tb.sv]
// self-checking testbench for the escaped length frame receiver
`default_nettype none

module tb;
  import elfr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic [2:0] {
    HUNT_HEADER  = 3'd0,
    LEN_MSB      = 3'd1,
    LEN_LSB      = 3'd2,
    DATA_BYTES   = 3'd3,
    CHECK_BYTE   = 3'd4,
    AFTER_ESCAPE = 3'd5
  } rx_phase_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  line_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  event_kind;
  logic [7:0]  payload_byte;
  logic [15:0] byte_position;
  logic [15:0] frame_length;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_MAX_LEN;
  logic [15:0] cfg_data = 16'h0000;

  escaped_length_frame_receiver_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .line_byte(line_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .event_kind(event_kind), .payload_byte(payload_byte),
    .byte_position(byte_position), .frame_length(frame_length),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // deframer mirror
  cfg_t        cfg_mirror = '{MAX_LEN_RESET, CAPACITY_RESET, HDR_CODE_RESET, ESC_CODE_RESET};
  rx_phase_t   rx_phase = HUNT_HEADER;
  rx_phase_t   resume_phase = HUNT_HEADER;
  logic [15:0] announced_len = 16'h0000;
  logic [15:0] taken_count = 16'h0000;
  logic [7:0]  xor_sum = 8'h00;

  result_t expected_events[$];
  int      failures = 0;
  int      bytes_sent = 0;
  int      cycle_count = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      stall_hold = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void clear_frame();
    rx_phase = HUNT_HEADER;
    resume_phase = HUNT_HEADER;
    announced_len = 16'h0000;
    taken_count = 16'h0000;
    xor_sum = 8'h00;
  endfunction

  function automatic void take_unstuffed(input rx_phase_t ph, input logic [7:0] u);
    result_t ev;
    ev = '0;
    case (ph)
      LEN_MSB: begin
        announced_len = {u, 8'h00};
        xor_sum ^= u;
        rx_phase = LEN_LSB;
      end
      LEN_LSB: begin
        announced_len[7:0] = u;
        xor_sum ^= u;
        if (announced_len > cfg_mirror.max_message_length) begin
          clear_frame();
        end else begin
          rx_phase = (announced_len == 16'h0000) ? CHECK_BYTE : DATA_BYTES;
        end
      end
      DATA_BYTES: begin
        if (taken_count >= cfg_mirror.frame_capacity) begin
          clear_frame();
          ev.kind = EV_OVERFLOW;
        end else begin
          ev.kind = EV_PAYLOAD;
          ev.payload_byte = u;
          ev.byte_position = taken_count;
          taken_count = taken_count + 16'd1;
          xor_sum ^= u;
          rx_phase = (taken_count >= announced_len) ? CHECK_BYTE : DATA_BYTES;
        end
        expected_events.push_back(ev);
      end
      CHECK_BYTE: begin
        if (xor_sum == u) begin
          ev.kind = EV_GOOD;
          ev.frame_length = announced_len;
        end else begin
          ev.kind = EV_CHECK_ERR;
        end
        clear_frame();
        expected_events.push_back(ev);
      end
      default: clear_frame();
    endcase
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    if (rx_phase == AFTER_ESCAPE) begin
      // header code is matched first when both codes are equal
      if (b == cfg_mirror.escaped_header_code) begin
        take_unstuffed(resume_phase, FRAME_HEAD);
      end else if (b == cfg_mirror.escaped_escape_code) begin
        take_unstuffed(resume_phase, ESCAPE_BYTE);
      end else begin
        clear_frame();
      end
    end else if (rx_phase != HUNT_HEADER) begin
      if (b == FRAME_HEAD) begin
        clear_frame();
        rx_phase = LEN_MSB;
      end else if (b == ESCAPE_BYTE) begin
        resume_phase = rx_phase;
        rx_phase = AFTER_ESCAPE;
      end else begin
        take_unstuffed(rx_phase, b);
      end
    end else if (b == FRAME_HEAD) begin
      clear_frame();
      rx_phase = LEN_MSB;
    end
  endfunction

  // valid stays high between back-to-back words, lowered only for a gap
  task automatic send_byte(input logic [7:0] b);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    line_byte <= b;
    do @(posedge clk); while (!in_ready);
    deframe_byte(b);
    bytes_sent++;
  endtask

  task automatic send_stuffed(input logic [7:0] b);
    if (b == FRAME_HEAD) begin
      send_byte(ESCAPE_BYTE);
      send_byte(cfg_mirror.escaped_header_code);
    end else if (b == ESCAPE_BYTE) begin
      send_byte(ESCAPE_BYTE);
      send_byte(cfg_mirror.escaped_escape_code);
    end else begin
      send_byte(b);
    end
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg_word(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MAX_LEN:  cfg_mirror.max_message_length = data;
      CFG_CAPACITY: cfg_mirror.frame_capacity = data;
      CFG_HDR_CODE: cfg_mirror.escaped_header_code = data[7:0];
      CFG_ESC_CODE: cfg_mirror.escaped_escape_code = data[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [15:0] max_len, input logic [15:0] cap,
                                input logic [7:0] hdr_code, input logic [7:0] esc_code);
    write_cfg_word(CFG_MAX_LEN, max_len);
    write_cfg_word(CFG_CAPACITY, cap);
    write_cfg_word(CFG_HDR_CODE, {8'h00, hdr_code});
    write_cfg_word(CFG_ESC_CODE, {8'h00, esc_code});
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // mostly well-formed frames, some with leading junk bytes, a bad escape,
  // truncation, an oversize length or a corrupted checksum
  task automatic send_random_frame();
    logic [15:0] len;
    logic [7:0]  sum;
    logic [7:0]  d;
    int          r;
    int          stop_at;
    int          bad_esc_at;
    bit          oversize;
    oversize = 1'b0;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
    end
    r = $urandom_range(99);
    if (r < 3) begin
      len = {8'h00, ($urandom_range(1) != 0) ? FRAME_HEAD : ESCAPE_BYTE};
    end else if (r < 6) begin
      len = 16'hFFFF;
      oversize = 1'b1;
    end else if (r < 14 && cfg_mirror.max_message_length != 16'hFFFF) begin
      len = cfg_mirror.max_message_length + 16'd1;
      oversize = 1'b1;
    end else if (r < 24) begin
      len = 16'($urandom_range(13, 64));
    end else begin
      len = 16'($urandom_range(0, 12));
    end
    if (!oversize && len > cfg_mirror.max_message_length) begin
      len = 16'($urandom_range(0, cfg_mirror.max_message_length));
    end
    stop_at = (len > 16'd130) ? $urandom_range(0, 40) : int'(len);
    if (len != 16'h0000 && $urandom_range(99) < 5) stop_at = $urandom_range(0, len - 1);
    bad_esc_at = ($urandom_range(99) < 4) ? $urandom_range(0, stop_at) : -1;

    send_byte(FRAME_HEAD);
    send_stuffed(len[15:8]);
    send_stuffed(len[7:0]);
    sum = len[15:8] ^ len[7:0];
    for (int i = 0; i < stop_at; i++) begin
      if (i == bad_esc_at) begin
        do d = 8'($urandom_range(255));
        while (d == cfg_mirror.escaped_header_code || d == cfg_mirror.escaped_escape_code);
        send_byte(ESCAPE_BYTE);
        send_byte(d);
        return;
      end
      d = 8'($urandom_range(255));
      if ($urandom_range(99) < 20) d = ($urandom_range(1) != 0) ? FRAME_HEAD : ESCAPE_BYTE;
      sum ^= d;
      send_stuffed(d);
    end
    // truncated frame: the next header restarts the deframer
    if (stop_at != int'(len)) return;
    if ($urandom_range(99) < 8) sum ^= 8'(1 << $urandom_range(7));
    send_stuffed(sum);
  endtask

  task automatic test_basic_frames();
    // zero-length frame: checksum right after the length
    send_byte(FRAME_HEAD);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    // stuffed header byte as data
    send_byte(FRAME_HEAD);
    send_byte(8'h00);
    send_byte(8'h01);
    send_stuffed(FRAME_HEAD);
    send_byte(8'h01 ^ FRAME_HEAD);
    // checksum that needs stuffing
    send_byte(FRAME_HEAD);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'h01 ^ ESCAPE_BYTE);
    send_stuffed(ESCAPE_BYTE);
    // checksum error
    send_byte(FRAME_HEAD);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'hFF);
    send_byte(8'h00);
    // header inside the length restarts, then a length above the limit
    send_byte(FRAME_HEAD);
    send_byte(8'h00);
    send_byte(FRAME_HEAD);
    send_byte(8'h04);
    send_byte(8'h01);
    // header byte right after an escape is a bad escape code
    send_byte(FRAME_HEAD);
    send_byte(ESCAPE_BYTE);
    send_byte(FRAME_HEAD);
    wait_all_results();
  endtask

  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    // receiver holds off while frames keep coming, so the input must stall
    stall_hold = 300;
    repeat (6) send_random_frame();
    wait_all_results();
    repeat (4) send_random_frame();
    wait_all_results();
  endtask

  task automatic run_random_phase(input logic [15:0] max_len, input logic [15:0] cap,
                                  input logic [7:0] hdr_code, input logic [7:0] esc_code,
                                  input int send_pct, input int recv_pct, input int n_bytes);
    int start_count;
    wait_all_results();
    apply_settings(max_len, cap, hdr_code, esc_code);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    start_count = bytes_sent;
    while (bytes_sent - start_count < n_bytes) send_random_frame();
    wait_all_results();
  endtask

  task automatic test_random_traffic();
    run_random_phase(MAX_LEN_RESET, CAPACITY_RESET, HDR_CODE_RESET, ESC_CODE_RESET,
                     0, 0, 90);
    run_random_phase(16'h0000, 16'h0001, 8'h00, 8'hFF, 84, 0, 90);
    run_random_phase(16'hFFFF, 16'hFFFF, 8'hFF, 8'h00, 0, 84, 90);
    run_random_phase(16'd16, 16'h0001, FRAME_HEAD, ESCAPE_BYTE, 30, 30, 90);
    // equal codes: the header code wins
    run_random_phase(16'd8, 16'd4, 8'h33, 8'h33, 0, 0, 90);
    run_random_phase(16'hFFFF, 16'd3, ESCAPE_BYTE, FRAME_HEAD, 84, 84, 90);
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_events.size() == 0) begin
        $error("unexpected word: kind %0d", event_kind);
        failures++;
      end else begin
        want = expected_events.pop_front();
        if (event_kind != want.kind) begin
          $error("event_kind: expected %0d, got %0d", want.kind, event_kind);
          failures++;
        end
        if (payload_byte != want.payload_byte) begin
          $error("payload_byte: expected %0h, got %0h", want.payload_byte, payload_byte);
          failures++;
        end
        if (byte_position != want.byte_position) begin
          $error("byte_position: expected %0d, got %0d", want.byte_position, byte_position);
          failures++;
        end
        if (frame_length != want.frame_length) begin
          $error("frame_length: expected %0d, got %0d", want.frame_length, frame_length);
          failures++;
        end
      end
    end
    if (stall_hold > 0) begin
      stall_hold--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_frames();
    test_output_stall();
    test_random_traffic();
    wait_all_results();
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
hw/rtl/elfr_pkg.sv
hw/rtl/elfr_cfg.sv
hw/rtl/elfr_core.sv
hw/rtl/elfr_out.sv
hw/rtl/escaped_length_frame_receiver_top.sv
test/tb.sv
